// ----- sv/cdlp_pkg.sv -----
// Shared types, character codes and constants of the color and distance line parser.
package cdlp_pkg;

    // Register indexes of the configuration port.
    localparam int unsigned CFG_INDEX_BITS = 1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MAX_LINE_LENGTH = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_TIMEOUT_MS      = 1'b1;
    localparam int unsigned CFG_DATA_BITS = 16;

    localparam logic [6:0]  MAX_LINE_LENGTH_RESET = 7'd64;
    localparam logic [15:0] TIMEOUT_MS_RESET      = 16'd300;

    // Input action codes.
    localparam logic ACT_BYTE = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    // Result event codes.
    localparam logic EV_LINE    = 1'b0;
    localparam logic EV_EXPIRED = 1'b1;

    // Color codes.
    localparam logic [1:0] COLOR_NONE  = 2'd0;
    localparam logic [1:0] COLOR_RED   = 2'd1;
    localparam logic [1:0] COLOR_BLUE  = 2'd2;
    localparam logic [1:0] COLOR_GREEN = 2'd3;

    // Character codes.
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_N     = 8'h4E;
    localparam logic [7:0] CH_R_UP  = 8'h52;
    localparam logic [7:0] CH_B_UP  = 8'h42;
    localparam logic [7:0] CH_G_UP  = 8'h47;
    localparam logic [7:0] CH_R_LO  = 8'h72;
    localparam logic [7:0] CH_B_LO  = 8'h62;
    localparam logic [7:0] CH_G_LO  = 8'h67;

    // Queue between the classifier and the parser.
    localparam int unsigned QUEUE_DEPTH = 2;

    // Class of one queued word.
    typedef enum logic [2:0] {
        K_TICK,
        K_NL,
        K_DIGIT,
        K_DOT,
        K_COMMA,
        K_N,
        K_COLOR,
        K_OTHER
    } t_kind;

    // A classified word: the digit value or the color code rides in val.
    typedef struct packed {
        t_kind      kind;
        logic [3:0] val;
    } t_entry;

    typedef struct packed {
        logic   valid;
        t_entry entry;
    } t_q_head;

    typedef struct packed {
        logic [6:0]  max_line_length;
        logic [15:0] timeout_ms;
    } t_cfg;

    // Powers of ten up to the largest supported fraction length.
    function automatic logic [19:0] pow10(input logic [2:0] n);
        logic [19:0] v;
        unique case (n)
            3'd0:    v = 20'd1;
            3'd1:    v = 20'd10;
            3'd2:    v = 20'd100;
            3'd3:    v = 20'd1000;
            3'd4:    v = 20'd10000;
            3'd5:    v = 20'd100000;
            3'd6:    v = 20'd1000000;
            default: v = 20'd1;
        endcase
        return v;
    endfunction

endpackage

// ----- sv/cdlp_if.sv -----
// Handshake interfaces for the input, result and configuration channels.
interface cdlp_in_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [7:0] byte_value;

    modport source (output valid, output action, output byte_value, input ready);
    modport sink   (input valid, input action, input byte_value, output ready);
endinterface

interface cdlp_out_if;
    logic        valid;
    logic        ready;
    logic        event_kind;
    logic [1:0]  color;
    logic [31:0] distance;
    logic        reading_valid;
    logic        saturated;

    modport source (output valid, output event_kind, output color, output distance,
                    output reading_valid, output saturated, input ready);
    modport sink   (input valid, input event_kind, input color, input distance,
                    input reading_valid, input saturated, output ready);
endinterface

interface cdlp_cfg_if;
    logic                                 valid;
    logic                                 ready;
    logic [cdlp_pkg::CFG_INDEX_BITS-1:0]  index;
    logic [cdlp_pkg::CFG_DATA_BITS-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- sv/cdlp_front.sv -----
// Front end: classifies incoming words, drops carriage returns and queues the rest.
module cdlp_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    cdlp_in_if.sink            i_item,
    output cdlp_pkg::t_q_head  o_head,
    input  logic               i_pop
);
    localparam int unsigned PTR_BITS = $clog2(cdlp_pkg::QUEUE_DEPTH);
    localparam int unsigned CNT_BITS = $clog2(cdlp_pkg::QUEUE_DEPTH + 1);

    cdlp_pkg::t_entry r_q [cdlp_pkg::QUEUE_DEPTH];
    logic [PTR_BITS-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_BITS-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_BITS-1:0] r_count, n_count;

    cdlp_pkg::t_entry w_entry;
    logic [7:0]       w_digit;
    logic             w_accept;
    logic             w_push;
    logic             w_pop;

    assign w_digit = i_item.byte_value - cdlp_pkg::CH_ZERO;

    always_comb begin
        w_entry.kind = cdlp_pkg::K_OTHER;
        w_entry.val  = 4'd0;
        priority if (i_item.action == cdlp_pkg::ACT_TICK) begin
            w_entry.kind = cdlp_pkg::K_TICK;
        end else if (i_item.byte_value == cdlp_pkg::CH_NL) begin
            w_entry.kind = cdlp_pkg::K_NL;
        end else if (i_item.byte_value >= cdlp_pkg::CH_ZERO &&
                     i_item.byte_value <= cdlp_pkg::CH_NINE) begin
            w_entry.kind = cdlp_pkg::K_DIGIT;
            w_entry.val  = w_digit[3:0];
        end else if (i_item.byte_value == cdlp_pkg::CH_DOT) begin
            w_entry.kind = cdlp_pkg::K_DOT;
        end else if (i_item.byte_value == cdlp_pkg::CH_COMMA) begin
            w_entry.kind = cdlp_pkg::K_COMMA;
        end else if (i_item.byte_value == cdlp_pkg::CH_N) begin
            w_entry.kind = cdlp_pkg::K_N;
        end else if (i_item.byte_value == cdlp_pkg::CH_R_UP ||
                     i_item.byte_value == cdlp_pkg::CH_R_LO) begin
            w_entry.kind = cdlp_pkg::K_COLOR;
            w_entry.val  = {2'b00, cdlp_pkg::COLOR_RED};
        end else if (i_item.byte_value == cdlp_pkg::CH_B_UP ||
                     i_item.byte_value == cdlp_pkg::CH_B_LO) begin
            w_entry.kind = cdlp_pkg::K_COLOR;
            w_entry.val  = {2'b00, cdlp_pkg::COLOR_BLUE};
        end else if (i_item.byte_value == cdlp_pkg::CH_G_UP ||
                     i_item.byte_value == cdlp_pkg::CH_G_LO) begin
            w_entry.kind = cdlp_pkg::K_COLOR;
            w_entry.val  = {2'b00, cdlp_pkg::COLOR_GREEN};
        end else begin
            w_entry.kind = cdlp_pkg::K_OTHER;
        end
    end

    assign i_item.ready = (r_count != CNT_BITS'(cdlp_pkg::QUEUE_DEPTH));
    assign w_accept     = i_item.valid && i_item.ready;
    // A carriage return changes nothing downstream, so it never enters the queue.
    assign w_push = w_accept && !(i_item.action == cdlp_pkg::ACT_BYTE &&
                                  i_item.byte_value == cdlp_pkg::CH_CR);
    assign w_pop  = i_pop && (r_count != '0);

    assign o_head.valid = (r_count != '0);
    assign o_head.entry = r_q[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_BITS'(cdlp_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                         : r_wr_ptr + 1'b1;
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_BITS'(cdlp_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                         : r_rd_ptr + 1'b1;
        end
        unique case ({w_push, w_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr_ptr] <= w_entry;
        end
    end

endmodule

// ----- sv/cdlp_back.sv -----
// Back end: line parser, fixed point accumulator, reading age timer and result register.
module cdlp_back #(
    parameter int unsigned FRACTION_DIGITS = 4,
    parameter int unsigned DISTANCE_BITS   = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  cdlp_pkg::t_cfg     i_cfg,
    input  cdlp_pkg::t_q_head  i_head,
    output logic               o_pop,
    cdlp_out_if.source         o_result
);
    localparam int unsigned FW = $clog2(FRACTION_DIGITS + 1);
    localparam int unsigned AW = ((DISTANCE_BITS > 28) ? DISTANCE_BITS : 28) + 4;
    localparam logic [DISTANCE_BITS-1:0] DIST_MAX = '1;
    localparam logic [AW-1:0] DIST_MAX_EXT = AW'(DIST_MAX);

    typedef enum logic [7:0] {
        PH_START = 8'b0000_0001,
        PH_N1    = 8'b0000_0010,
        PH_N2    = 8'b0000_0100,
        PH_N3    = 8'b0000_1000,
        PH_COLOR = 8'b0001_0000,
        PH_INT   = 8'b0010_0000,
        PH_FRAC  = 8'b0100_0000,
        PH_BAD   = 8'b1000_0000
    } t_phase;

    t_phase                  r_phase, n_phase;
    logic [6:0]              r_line_count, n_line_count;
    logic [1:0]              r_pend_color, n_pend_color;
    logic [DISTANCE_BITS-1:0] r_accum, n_accum;
    logic [FW-1:0]           r_frac, n_frac;
    logic                    r_digit_seen, n_digit_seen;
    logic                    r_acc_sat, n_acc_sat;
    logic [15:0]             r_age, n_age;
    logic                    r_has_packet, n_has_packet;
    logic                    r_out_valid, n_out_valid;

    logic                    r_ev, n_ev;
    logic [1:0]              r_color, n_color;
    logic [31:0]             r_dist, n_dist;
    logic                    r_rv, n_rv;
    logic                    r_sat, n_sat;

    logic                    w_go;
    logic                    w_emit;
    cdlp_pkg::t_entry        w_e;

    logic [AW-1:0]           w_acc_ext;
    logic [AW-1:0]           w_times10;
    logic                    w_base_sat;
    logic [DISTANCE_BITS-1:0] w_base;
    logic [2:0]              w_exp;
    logic [19:0]             w_scale;
    logic [23:0]             w_prod;
    logic [AW-1:0]           w_sum;
    logic                    w_sum_sat;
    logic [DISTANCE_BITS-1:0] w_sum_clamped;

    assign w_e  = i_head.entry;
    assign w_go = i_head.valid && (!r_out_valid || o_result.ready);
    assign o_pop = w_go;

    // Digit step: in the integer part the accumulator is multiplied by ten first
    // and the digit weighs 10^FRACTION_DIGITS; in the fraction part the digit weight
    // falls by ten per place.
    assign w_acc_ext  = AW'(r_accum);
    assign w_times10  = (w_acc_ext << 3) + (w_acc_ext << 1);
    assign w_base_sat = (w_times10 > DIST_MAX_EXT);
    assign w_base     = (r_phase == PH_INT) ? (w_base_sat ? DIST_MAX
                                                          : w_times10[DISTANCE_BITS-1:0])
                                            : r_accum;
    assign w_exp      = (r_phase == PH_INT) ? 3'(FRACTION_DIGITS)
                                            : 3'(FRACTION_DIGITS - 1) - 3'(r_frac);
    assign w_scale    = cdlp_pkg::pow10(w_exp);
    assign w_prod     = 24'(w_e.val) * 24'(w_scale);
    assign w_sum      = AW'(w_base) + AW'(w_prod);
    assign w_sum_sat  = (w_sum > DIST_MAX_EXT);
    assign w_sum_clamped = w_sum_sat ? DIST_MAX : w_sum[DISTANCE_BITS-1:0];

    always_comb begin
        n_phase      = r_phase;
        n_line_count = r_line_count;
        n_pend_color = r_pend_color;
        n_accum      = r_accum;
        n_frac       = r_frac;
        n_digit_seen = r_digit_seen;
        n_acc_sat    = r_acc_sat;
        n_age        = r_age;
        n_has_packet = r_has_packet;
        n_out_valid  = r_out_valid && !o_result.ready;
        w_emit       = 1'b0;
        n_ev         = r_ev;
        n_color      = r_color;
        n_dist       = r_dist;
        n_rv         = r_rv;
        n_sat        = r_sat;

        if (w_go) begin
            unique case (w_e.kind)
                cdlp_pkg::K_TICK: begin
                    if (r_has_packet) begin
                        if (r_age >= i_cfg.timeout_ms) begin
                            n_has_packet = 1'b0;
                            w_emit = 1'b1;
                            n_ev    = cdlp_pkg::EV_EXPIRED;
                            n_color = cdlp_pkg::COLOR_NONE;
                            n_dist  = 32'd0;
                            n_rv    = 1'b0;
                            n_sat   = 1'b0;
                        end else begin
                            n_age = r_age + 16'd1;
                        end
                    end
                end
                cdlp_pkg::K_NL: begin
                    if (r_phase == PH_N3) begin
                        w_emit  = 1'b1;
                        n_ev    = cdlp_pkg::EV_LINE;
                        n_color = cdlp_pkg::COLOR_NONE;
                        n_dist  = 32'd0;
                        n_rv    = 1'b0;
                        n_sat   = 1'b0;
                    end else if ((r_phase == PH_INT || r_phase == PH_FRAC) && r_digit_seen) begin
                        w_emit  = 1'b1;
                        n_ev    = cdlp_pkg::EV_LINE;
                        n_color = r_pend_color;
                        n_dist  = w_acc_ext[31:0];
                        n_rv    = 1'b1;
                        n_sat   = r_acc_sat;
                    end
                    if (w_emit) begin
                        n_age        = 16'd0;
                        n_has_packet = 1'b1;
                    end
                    n_phase      = PH_START;
                    n_line_count = 7'd0;
                    n_pend_color = cdlp_pkg::COLOR_NONE;
                    n_accum      = '0;
                    n_frac       = '0;
                    n_digit_seen = 1'b0;
                    n_acc_sat    = 1'b0;
                end
                default: begin
                    if (r_line_count >= i_cfg.max_line_length) begin
                        // Overlong line: drop it together with this byte.
                        n_phase      = PH_START;
                        n_line_count = 7'd0;
                        n_pend_color = cdlp_pkg::COLOR_NONE;
                        n_accum      = '0;
                        n_frac       = '0;
                        n_digit_seen = 1'b0;
                        n_acc_sat    = 1'b0;
                    end else begin
                        n_line_count = r_line_count + 7'd1;
                        unique case (r_phase)
                            PH_START: begin
                                if (w_e.kind == cdlp_pkg::K_N) begin
                                    n_phase = PH_N1;
                                end else if (w_e.kind == cdlp_pkg::K_COLOR) begin
                                    n_pend_color = w_e.val[1:0];
                                    n_phase      = PH_COLOR;
                                end else begin
                                    n_phase = PH_BAD;
                                end
                            end
                            PH_N1: begin
                                n_phase = (w_e.kind == cdlp_pkg::K_COMMA) ? PH_N2 : PH_BAD;
                            end
                            PH_N2: begin
                                n_phase = (w_e.kind == cdlp_pkg::K_DIGIT && w_e.val == 4'd0)
                                          ? PH_N3 : PH_BAD;
                            end
                            PH_COLOR: begin
                                n_phase = (w_e.kind == cdlp_pkg::K_COMMA) ? PH_INT : PH_BAD;
                            end
                            PH_INT: begin
                                if (w_e.kind == cdlp_pkg::K_DIGIT) begin
                                    n_accum      = w_sum_clamped;
                                    n_acc_sat    = r_acc_sat | w_base_sat | w_sum_sat;
                                    n_digit_seen = 1'b1;
                                end else if (w_e.kind == cdlp_pkg::K_DOT) begin
                                    n_phase = PH_FRAC;
                                end else begin
                                    n_phase = PH_BAD;
                                end
                            end
                            PH_FRAC: begin
                                if (w_e.kind == cdlp_pkg::K_DIGIT) begin
                                    // Digits past the kept places are checked but dropped.
                                    if (r_frac < FW'(FRACTION_DIGITS)) begin
                                        n_accum   = w_sum_clamped;
                                        n_acc_sat = r_acc_sat | w_sum_sat;
                                        n_frac    = r_frac + 1'b1;
                                    end
                                    n_digit_seen = 1'b1;
                                end else begin
                                    n_phase = PH_BAD;
                                end
                            end
                            default: begin
                                n_phase = PH_BAD;
                            end
                        endcase
                    end
                end
            endcase
            if (w_emit) begin
                n_out_valid = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_START;
            r_line_count <= 7'd0;
            r_pend_color <= cdlp_pkg::COLOR_NONE;
            r_accum      <= '0;
            r_frac       <= '0;
            r_digit_seen <= 1'b0;
            r_acc_sat    <= 1'b0;
            r_age        <= 16'd0;
            r_has_packet <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_phase      <= n_phase;
            r_line_count <= n_line_count;
            r_pend_color <= n_pend_color;
            r_accum      <= n_accum;
            r_frac       <= n_frac;
            r_digit_seen <= n_digit_seen;
            r_acc_sat    <= n_acc_sat;
            r_age        <= n_age;
            r_has_packet <= n_has_packet;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_ev    <= n_ev;
            r_color <= n_color;
            r_dist  <= n_dist;
            r_rv    <= n_rv;
            r_sat   <= n_sat;
        end
    end

    assign o_result.valid         = r_out_valid;
    assign o_result.event_kind    = r_ev;
    assign o_result.color         = r_color;
    assign o_result.distance      = r_dist;
    assign o_result.reading_valid = r_rv;
    assign o_result.saturated     = r_sat;

endmodule

// ----- sv/color_distance_line_parser.sv -----
// Top level of the color and distance line parser: configuration registers and the two halves.
//
//   Channel   Dir  Handshake        Word contents
//   i_item    in   valid / ready    action, byte_value (serial byte or 1 ms tick)
//   o_result  out  valid / ready    event_kind, color, distance, reading_valid, saturated
//   i_cfg     in   valid / ready    index (0 max_line_length, 1 timeout_ms), data
//
// The block sustains one input word per clock cycle while the queue has room. The classifier
// takes a word and places it in a two-entry queue; the parser retires one queued word per
// cycle while the result is not stalled, and a result sits in the output register from the
// cycle after its word is parsed. The digit step (multiply by ten, add the weighted digit,
// clamp) is the longest path. Reset is synchronous; no clearing pass follows it.
// A stalled result holds the parser, and the queue keeps taking words until it is full.
module color_distance_line_parser #(
    parameter int unsigned FRACTION_DIGITS = 4,
    parameter int unsigned DISTANCE_BITS   = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    cdlp_in_if.sink     i_item,
    cdlp_out_if.source  o_result,
    cdlp_cfg_if.sink    i_cfg
);
    cdlp_pkg::t_cfg    r_cfg;
    cdlp_pkg::t_q_head w_head;
    logic              w_pop;

    // Configuration writes are always taken; the user sends them only while the block is idle.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_line_length <= cdlp_pkg::MAX_LINE_LENGTH_RESET;
            r_cfg.timeout_ms      <= cdlp_pkg::TIMEOUT_MS_RESET;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                cdlp_pkg::CFG_MAX_LINE_LENGTH: r_cfg.max_line_length <= i_cfg.data[6:0];
                cdlp_pkg::CFG_TIMEOUT_MS:      r_cfg.timeout_ms      <= i_cfg.data[15:0];
                default: ;
            endcase
        end
    end

    // Front end: classification and the queue.
    cdlp_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_item),
        .o_head  (w_head),
        .i_pop   (w_pop)
    );

    // Back end: parse state, accumulator, age timer and the result register.
    cdlp_back #(
        .FRACTION_DIGITS (FRACTION_DIGITS),
        .DISTANCE_BITS   (DISTANCE_BITS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_head   (w_head),
        .o_pop    (w_pop),
        .o_result (o_result)
    );

endmodule

// ----- sv/cdlp_checker.sv -----
// Port-level checker for the color and distance line parser and its bind statement.
module cdlp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic        i_out_event_kind,
    input logic [1:0]  i_out_color,
    input logic [31:0] i_out_distance,
    input logic        i_out_reading_valid,
    input logic        i_out_saturated
);

    // A stalled result word stays and keeps its contents.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid &&
            $stable({i_out_event_kind, i_out_color, i_out_distance,
                     i_out_reading_valid, i_out_saturated}))
        else $error("result word changed while stalled");

    // Right after reset nothing is pending and the input is ready.
    a_reset_idle: assert property (@(posedge i_clk)
        i_rst_n && !$past(i_rst_n) |-> !i_out_valid && i_in_ready)
        else $error("block not idle after reset");

    // Empty readings and expiries carry no color, distance or saturation.
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_reading_valid |->
            i_out_color == cdlp_pkg::COLOR_NONE && i_out_distance == 32'd0 &&
            !i_out_saturated)
        else $error("empty reading carries data");

    // A colored reading is always a line result with a real color.
    a_reading_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_reading_valid |->
            i_out_event_kind == cdlp_pkg::EV_LINE && i_out_color != cdlp_pkg::COLOR_NONE)
        else $error("colored reading with wrong kind or no color");

endmodule

bind color_distance_line_parser cdlp_checker u_cdlp_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .i_in_ready          (i_item.ready),
    .i_out_valid         (o_result.valid),
    .i_out_ready         (o_result.ready),
    .i_out_event_kind    (o_result.event_kind),
    .i_out_color         (o_result.color),
    .i_out_distance      (o_result.distance),
    .i_out_reading_valid (o_result.reading_valid),
    .i_out_saturated     (o_result.saturated)
);
